@@ sv/vse_pkg.sv @@
package vse_pkg;

	// field widths
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 8;

	// stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 80;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FEW   = 2'd3;

	typedef logic [VALUE_W-1:0] word_t;

endpackage

@@ sv/value_stack_engine.sv @@
// LIFO stack engine: each input beat yields one result beat from the output register; pop
// with two or more entries and swap with two or more entries also wait for one RAM read.
// A new command is taken only after the last result enters the output register, so a stalled
// output holds the input; the top entry sits in a register, the rest in a RAM with registered read data.
// Reset (arst_n, asynchronous, active low) empties the stack; RAM is not cleared.
module value_stack_engine #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// command [2:0], push_value [66:3], zero pad [71:67]
	input  logic [vse_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_value [63:0], status [65:64], depth [73:66], zero pad [79:74]
	output logic [vse_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [PTR_W-1:0] FULL_P = PTR_W'(STACK_DEPTH);
	localparam logic [PTR_W-1:0] ONE_P  = PTR_W'(1);
	localparam logic [PTR_W-1:0] TWO_P  = PTR_W'(2);
	localparam int PAD_W = vse_pkg::OUT_TDATA_W - vse_pkg::VALUE_W - vse_pkg::STATUS_W
		- vse_pkg::DEPTH_W;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                        state_q;
	logic [PTR_W-1:0]                  sp_q;
	vse_pkg::word_t                    top_q;
	logic [vse_pkg::CMD_W-1:0]         cmd_q;
	vse_pkg::word_t                    res_value_q;
	logic [vse_pkg::STATUS_W-1:0]      res_status_q;
	logic                              m_tvalid_q;
	logic [vse_pkg::OUT_TDATA_W-1:0]   m_tdata_q;

	logic [vse_pkg::CMD_W-1:0]         in_cmd;
	vse_pkg::word_t                    in_value;
	logic                              accept;
	logic [PTR_W-1:0]                  sp_m1;
	logic [PTR_W-1:0]                  sp_m2;
	logic [PTR_W+vse_pkg::DEPTH_W-1:0] sp_ext;
	logic                              ram_we;
	logic [ADDR_W-1:0]                 ram_waddr;
	vse_pkg::word_t                    ram_wdata;
	vse_pkg::word_t                    ram_rdata;
	logic                              out_free;

	assign in_cmd   = s_tdata[vse_pkg::CMD_W-1:0];
	assign in_value = s_tdata[vse_pkg::CMD_W +: vse_pkg::VALUE_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign sp_m1    = sp_q - ONE_P;
	assign sp_m2    = sp_q - TWO_P;
	assign sp_ext   = {{vse_pkg::DEPTH_W{1'b0}}, sp_q};
	assign out_free = !m_tvalid_q || m_tready;

	// RAM holds every entry below the top; write spills or swaps, read fetches sp-2
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sp_m1[ADDR_W-1:0];
		ram_wdata = top_q;
		if (accept) begin
			case (in_cmd)
				vse_pkg::CMD_PUSH: ram_we = (sp_q != '0) && (sp_q < FULL_P);
				vse_pkg::CMD_DUP:  ram_we = (sp_q != '0) && (sp_q < FULL_P);
				default:           ram_we = 1'b0;
			endcase
		end else if (state_q == S_RD && cmd_q == vse_pkg::CMD_SWAP) begin
			ram_we    = 1'b1;
			ram_waddr = sp_m2[ADDR_W-1:0];
		end
	end

	vse_ram #(
		.DEPTH  (STACK_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (sp_m2[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						case (in_cmd)
							vse_pkg::CMD_PUSH: begin
								if (sp_q < FULL_P) sp_q <= sp_q + ONE_P;
							end
							vse_pkg::CMD_POP: begin
								if (sp_q != '0) begin
									sp_q <= sp_m1;
									if (sp_q >= TWO_P) state_q <= S_RD;
								end
							end
							vse_pkg::CMD_DUP: begin
								if (sp_q != '0 && sp_q < FULL_P) sp_q <= sp_q + ONE_P;
							end
							vse_pkg::CMD_SWAP: begin
								if (sp_q >= TWO_P) state_q <= S_RD;
							end
							vse_pkg::CMD_CLEAR: sp_q <= '0;
							default: ;
						endcase
					end
				end
				S_RD:    state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// top register and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= in_cmd;
			res_value_q  <= '0;
			res_status_q <= vse_pkg::ST_OK;
			case (in_cmd)
				vse_pkg::CMD_PUSH: begin
					if (sp_q < FULL_P) top_q <= in_value;
					else res_status_q <= vse_pkg::ST_FULL;
				end
				vse_pkg::CMD_POP, vse_pkg::CMD_PEEK: begin
					if (sp_q != '0) res_value_q <= top_q;
					else res_status_q <= vse_pkg::ST_EMPTY;
				end
				vse_pkg::CMD_DUP: begin
					if (sp_q == '0) res_status_q <= vse_pkg::ST_EMPTY;
					else if (sp_q >= FULL_P) res_status_q <= vse_pkg::ST_FULL;
				end
				vse_pkg::CMD_SWAP: begin
					if (sp_q < TWO_P) res_status_q <= vse_pkg::ST_FEW;
				end
				default: ;
			endcase
		end else if (state_q == S_RD) begin
			// new top after pop, or lower word of a swap
			top_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {{PAD_W{1'b0}}, sp_ext[vse_pkg::DEPTH_W-1:0], res_status_q,
				res_value_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sv/vse_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data
module vse_ram #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  vse_pkg::word_t       wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output vse_pkg::word_t       rdata
);

	vse_pkg::word_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 128;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_LEN    = 300;
	localparam int TAIL_CYCLES = 12;

	// codes the block must treat as no operation
	localparam logic [vse_pkg::CMD_W-1:0] CMD_NOP6 = 3'd6;
	localparam logic [vse_pkg::CMD_W-1:0] CMD_NOP7 = 3'd7;

	localparam vse_pkg::word_t WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam vse_pkg::word_t WORD_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [vse_pkg::CMD_W-1:0] cmd;
		vse_pkg::word_t            value;
	} stack_cmd_t;

	typedef struct packed {
		vse_pkg::word_t               read_value;
		logic [vse_pkg::STATUS_W-1:0] status;
		logic [vse_pkg::DEPTH_W-1:0]  depth;
	} stack_reply_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [vse_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [vse_pkg::OUT_TDATA_W-1:0] m_tdata;

	// shadow of the stack contents and fill level
	vse_pkg::word_t stack_words [STACK_DEPTH];
	int unsigned    stack_fill = 0;

	stack_cmd_t   command_q [$];
	stack_reply_t reply_q [$];
	stack_cmd_t   on_bus;

	int send_idle_pct  = 17;
	int recv_idle_pct  = 53;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int issued_count   = 0;
	int reply_count    = 0;
	int mismatch_count = 0;

	value_stack_engine #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one command to the shadow stack, return the reply it should give
	function automatic stack_reply_t apply_command(stack_cmd_t c);
		stack_reply_t   r;
		vse_pkg::word_t held;
		r = '0;
		r.status = vse_pkg::ST_OK;
		case (c.cmd)
			vse_pkg::CMD_PUSH: begin
				if (stack_fill < STACK_DEPTH) begin
					stack_words[stack_fill] = c.value;
					stack_fill++;
				end else begin
					r.status = vse_pkg::ST_FULL;
				end
			end
			vse_pkg::CMD_POP: begin
				if (stack_fill > 0) begin
					stack_fill--;
					r.read_value = stack_words[stack_fill];
				end else begin
					r.status = vse_pkg::ST_EMPTY;
				end
			end
			vse_pkg::CMD_PEEK: begin
				if (stack_fill > 0) begin
					r.read_value = stack_words[stack_fill-1];
				end else begin
					r.status = vse_pkg::ST_EMPTY;
				end
			end
			vse_pkg::CMD_DUP: begin
				if (stack_fill == 0) begin
					r.status = vse_pkg::ST_EMPTY;
				end else if (stack_fill >= STACK_DEPTH) begin
					r.status = vse_pkg::ST_FULL;
				end else begin
					stack_words[stack_fill] = stack_words[stack_fill-1];
					stack_fill++;
				end
			end
			vse_pkg::CMD_SWAP: begin
				if (stack_fill > 1) begin
					held = stack_words[stack_fill-2];
					stack_words[stack_fill-2] = stack_words[stack_fill-1];
					stack_words[stack_fill-1] = held;
				end else begin
					r.status = vse_pkg::ST_FEW;
				end
			end
			vse_pkg::CMD_CLEAR: begin
				stack_fill = 0;
			end
			default: ;
		endcase
		r.depth = vse_pkg::DEPTH_W'(stack_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] %s", $realtime, what);
	endtask

	task automatic check_reply(input logic [vse_pkg::OUT_TDATA_W-1:0] beat);
		stack_reply_t got;
		stack_reply_t want;
		got.read_value = beat[vse_pkg::VALUE_W-1:0];
		got.status     = beat[vse_pkg::VALUE_W +: vse_pkg::STATUS_W];
		got.depth      = beat[vse_pkg::VALUE_W+vse_pkg::STATUS_W +: vse_pkg::DEPTH_W];
		reply_count++;
		if (reply_q.size() == 0) begin
			report_mismatch($sformatf("reply %0d arrived with none outstanding", reply_count));
		end else begin
			want = reply_q.pop_front();
			if (got.read_value !== want.read_value) begin
				report_mismatch($sformatf("reply %0d read_value: want %h got %h",
					reply_count, want.read_value, got.read_value));
			end
			if (got.status !== want.status) begin
				report_mismatch($sformatf("reply %0d status: want %0d got %0d",
					reply_count, want.status, got.status));
			end
			if (got.depth !== want.depth) begin
				report_mismatch($sformatf("reply %0d depth: want %0d got %0d",
					reply_count, want.depth, got.depth));
			end
		end
	endtask

	// driver: holds each beat until taken, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				reply_q.push_back(apply_command(on_bus));
			end
			if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				on_bus = command_q.pop_front();
				s_tdata  <= {{(vse_pkg::IN_TDATA_W-vse_pkg::CMD_W-vse_pkg::VALUE_W){1'b0}},
					on_bus.value, on_bus.cmd};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: checks each reply beat, throttles tready, serves long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_reply(m_tdata);
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic queue_cmd(input logic [vse_pkg::CMD_W-1:0] cmd, input vse_pkg::word_t value);
		stack_cmd_t c;
		c.cmd   = cmd;
		c.value = value;
		command_q.push_back(c);
		issued_count++;
	endtask

	function automatic vse_pkg::word_t pick_word();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			2:       return WORD_MAX;
			3:       return WORD_MIN;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// weighted so the stack drifts upward and sometimes reaches full
	function automatic logic [vse_pkg::CMD_W-1:0] pick_command();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 34)      return vse_pkg::CMD_PUSH;
		else if (r < 54) return vse_pkg::CMD_POP;
		else if (r < 64) return vse_pkg::CMD_PEEK;
		else if (r < 74) return vse_pkg::CMD_DUP;
		else if (r < 86) return vse_pkg::CMD_SWAP;
		else if (r < 89) return vse_pkg::CMD_CLEAR;
		else if (r < 95) return CMD_NOP6;
		else             return CMD_NOP7;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			queue_cmd(pick_command(), pick_word());
		end
	endtask

	// clear, grow to full with pushes and dups, then hit full on both
	task automatic queue_fill();
		queue_cmd(vse_pkg::CMD_CLEAR, pick_word());
		queue_cmd(vse_pkg::CMD_PUSH, pick_word());
		for (int i = 0; i < STACK_DEPTH + 1; i++) begin
			queue_cmd(($urandom_range(5) == 0) ? vse_pkg::CMD_DUP : vse_pkg::CMD_PUSH,
				pick_word());
			if ($urandom_range(9) == 0) begin
				queue_cmd(($urandom_range(1) == 0) ? vse_pkg::CMD_SWAP : vse_pkg::CMD_PEEK,
					pick_word());
			end
		end
		queue_cmd(vse_pkg::CMD_PUSH, pick_word());
		queue_cmd(vse_pkg::CMD_DUP, pick_word());
		queue_cmd(vse_pkg::CMD_PEEK, pick_word());
	endtask

	// from full down to empty, then the empty cases again
	task automatic queue_drain();
		for (int i = 0; i < STACK_DEPTH; i++) begin
			queue_cmd(vse_pkg::CMD_POP, pick_word());
			if ($urandom_range(7) == 0) begin
				queue_cmd(($urandom_range(1) == 0) ? vse_pkg::CMD_SWAP : vse_pkg::CMD_PEEK,
					pick_word());
			end
		end
		queue_cmd(vse_pkg::CMD_POP, pick_word());
		queue_cmd(vse_pkg::CMD_PEEK, pick_word());
		queue_cmd(vse_pkg::CMD_SWAP, pick_word());
		queue_cmd(vse_pkg::CMD_DUP, pick_word());
	endtask

	task automatic wait_replies_done();
		while (reply_count < issued_count) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty stack, single entry, extreme words, unused codes, clear
		queue_cmd(vse_pkg::CMD_POP, '0);
		queue_cmd(vse_pkg::CMD_PEEK, '0);
		queue_cmd(vse_pkg::CMD_DUP, '0);
		queue_cmd(vse_pkg::CMD_SWAP, '0);
		queue_cmd(vse_pkg::CMD_PUSH, WORD_MAX);
		queue_cmd(vse_pkg::CMD_SWAP, '1);
		queue_cmd(vse_pkg::CMD_PEEK, '1);
		queue_cmd(vse_pkg::CMD_PUSH, WORD_MIN);
		queue_cmd(vse_pkg::CMD_SWAP, '0);
		queue_cmd(vse_pkg::CMD_PEEK, '0);
		queue_cmd(vse_pkg::CMD_DUP, '0);
		queue_cmd(CMD_NOP6, '1);
		queue_cmd(CMD_NOP7, WORD_MAX);
		queue_cmd(vse_pkg::CMD_POP, '0);
		queue_cmd(vse_pkg::CMD_POP, '0);
		queue_cmd(vse_pkg::CMD_POP, '0);
		queue_cmd(vse_pkg::CMD_PUSH, '1);
		queue_cmd(vse_pkg::CMD_PUSH, '0);
		queue_cmd(vse_pkg::CMD_CLEAR, '1);
		queue_cmd(vse_pkg::CMD_POP, '0);
		queue_cmd(vse_pkg::CMD_PEEK, '0);
		queue_cmd(vse_pkg::CMD_SWAP, '0);
		wait_replies_done();

		// sender lightly idle, receiver heavily idle, one long receiver hold-off
		queue_random(150);
		queue_fill();
		hold_requests++;
		queue_random(150);
		wait_replies_done();

		send_idle_pct = 53;
		recv_idle_pct = 17;
		queue_random(150);
		wait_replies_done();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_fill();
		queue_drain();
		queue_random(100);
		wait_replies_done();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && reply_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
